### hw/rtl/swls_pkg.sv
// ----------------------------------------------------------------------------
// swls_pkg
// Shared types and constants for the sliding window latency statistics block.
// ----------------------------------------------------------------------------
package swls_pkg;

  localparam int unsigned SAMPLE_W    = 24;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned RATE_W      = 32;
  localparam int unsigned BIT_W       = 5;
  localparam int unsigned WINDOW_DEF  = 128;
  localparam int unsigned PCT_MIN     = 10;
  localparam int unsigned PCT_NUM     = 99;
  localparam int unsigned PCT_DEN     = 100;
  // floor(x/100) as (x*5243)>>19, exact for x below 43699
  localparam int unsigned PCT_RECIP   = 5243;
  localparam int unsigned PCT_RECIP_W = 13;
  localparam int unsigned PCT_SHIFT   = 19;
  localparam logic [RATE_W-1:0] RATE_SCALE = 32'd1000000000;

  typedef enum logic {
    DIV_MEAN = 1'b0,
    DIV_RATE = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     write;
    logic     div_start;
    div_sel_t div_sel;
    logic     scan_start;
    logic     pass_end;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic last_bit;
    logic mean_zero;
  } status_t;

endpackage

### hw/rtl/swls_div.sv
// ----------------------------------------------------------------------------
// swls_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swls_div #(
  parameter int unsigned DVW = 35,
  parameter int unsigned DSW = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int unsigned CNW = $clog2(DVW);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic [DSW-1:0] rem;
  logic [DSW-1:0] dvs;
  logic [DSW:0]   trial;
  logic           fits;

  assign trial = {rem, quotient[DVW-1]};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(DVW - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= DSW'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[DSW-1:0];
      end
      quotient <= {quotient[DVW-2:0], fits};
    end
  end

endmodule

### hw/rtl/swls_datapath.sv
// ----------------------------------------------------------------------------
// swls_datapath
// Sample window memory, scan accumulators, rank search and result registers.
// ----------------------------------------------------------------------------
module swls_datapath #(
  parameter int unsigned WINDOW = swls_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  swls_pkg::cmd_t                     cmd,
  output swls_pkg::status_t                  status,
  input  logic [swls_pkg::SAMPLE_W-1:0]      latency_us,
  output logic [swls_pkg::COUNT_W-1:0]       total_count,
  output logic [swls_pkg::SAMPLE_W-1:0]      mean_us,
  output logic [swls_pkg::SAMPLE_W-1:0]      min_us,
  output logic [swls_pkg::SAMPLE_W-1:0]      max_us,
  output logic [swls_pkg::SAMPLE_W-1:0]      pct99_us,
  output logic                               pct99_valid,
  output logic [swls_pkg::RATE_W-1:0]        rate_millifps
);

  localparam int unsigned SW_ = swls_pkg::SAMPLE_W;
  localparam int unsigned AW  = $clog2(WINDOW);
  localparam int unsigned CW  = $clog2(WINDOW + 1);
  localparam int unsigned SMW = SW_ + CW;
  localparam int unsigned DVW = (SMW > swls_pkg::RATE_W) ? SMW : swls_pkg::RATE_W;
  localparam int unsigned PW  = CW + $clog2(swls_pkg::PCT_DEN);
  localparam int unsigned PPW = PW + swls_pkg::PCT_RECIP_W;

  logic [SW_-1:0] mem [WINDOW];

  logic [CW-1:0]                   fill;
  logic [AW-1:0]                   oldest;
  logic [swls_pkg::COUNT_W-1:0]    total;
  logic [CW-1:0]                   idx;
  logic                            scan_active;
  logic                            rd_valid;
  logic [SW_-1:0]                  rd_data;
  logic [SMW-1:0]                  sum;
  logic [SW_-1:0]                  mn;
  logic [SW_-1:0]                  mx;
  logic [CW-1:0]                   less;
  logic [swls_pkg::BIT_W-1:0]      bit_idx;
  logic [SW_-1:0]                  prefix;
  logic [SW_-1:0]                  cand;
  logic [CW-1:0]                   rank;
  logic [SW_-1:0]                  mean;
  logic [swls_pkg::RATE_W-1:0]     rate;
  logic [SW_-1:0]                  held_pct;
  swls_pkg::div_sel_t              sel;
  logic [AW-1:0]                   wr_addr;
  logic                            full;
  logic                            stats_pass;
  logic [PW-1:0]                   pct_num;
  logic [PPW-1:0]                  pct_prod;
  logic                            div_done;
  logic [DVW-1:0]                  quot;
  logic [DVW-1:0]                  dvd;
  logic [SW_-1:0]                  dvs;
  logic                            pct_ok;

  assign full       = (fill == CW'(WINDOW));
  assign wr_addr    = full ? oldest : fill[AW-1:0];
  assign cand       = prefix | (SW_'(1) << bit_idx);
  assign stats_pass = (bit_idx == swls_pkg::BIT_W'(SW_ - 1));
  assign pct_ok     = (fill >= CW'(swls_pkg::PCT_MIN));

  // rank floor(n*99/100) as n minus ceil(n/100)
  assign pct_num  = PW'(fill) + PW'(swls_pkg::PCT_DEN - 1);
  assign pct_prod = PPW'(pct_num) * PPW'(swls_pkg::PCT_RECIP);
  assign rank     = fill - CW'(pct_prod >> swls_pkg::PCT_SHIFT);

  always_comb begin
    case (cmd.div_sel)
      swls_pkg::DIV_MEAN: begin
        dvd = DVW'(sum);
        dvs = SW_'(fill);
      end
      default: begin
        dvd = DVW'(swls_pkg::RATE_SCALE);
        dvs = mean;
      end
    endcase
  end

  swls_div #(
    .DVW (DVW),
    .DSW (SW_)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quotient (quot)
  );

  // window memory
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      mem[wr_addr] <= latency_us;
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      oldest      <= '0;
      total       <= '0;
      scan_active <= 1'b0;
      rd_valid    <= 1'b0;
      held_pct    <= '0;
    end else begin
      if (cmd.write) begin
        if (total != '1) begin
          total <= total + 1'b1;
        end
        if (full) begin
          oldest <= (oldest == AW'(WINDOW - 1)) ? '0 : oldest + 1'b1;
        end else begin
          fill <= fill + 1'b1;
        end
      end
      if (cmd.scan_start) begin
        scan_active <= 1'b1;
        rd_valid    <= 1'b0;
      end else if (scan_active) begin
        if (idx < fill) begin
          rd_valid <= 1'b1;
        end else begin
          rd_valid    <= 1'b0;
          scan_active <= 1'b0;
        end
      end else begin
        rd_valid <= 1'b0;
      end
      if (cmd.load_out && pct_ok) begin
        held_pct <= prefix;
      end
    end
  end

  // scan accumulators and rank search
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      sum     <= '0;
      mn      <= '1;
      mx      <= '0;
      prefix  <= '0;
      bit_idx <= swls_pkg::BIT_W'(SW_ - 1);
    end
    if (cmd.scan_start) begin
      idx  <= '0;
      less <= '0;
    end else begin
      if (scan_active && idx < fill) begin
        idx <= idx + 1'b1;
      end
      if (rd_valid) begin
        if (rd_data < cand) begin
          less <= less + 1'b1;
        end
        if (stats_pass) begin
          sum <= sum + SMW'(rd_data);
          if (rd_data < mn) mn <= rd_data;
          if (rd_data > mx) mx <= rd_data;
        end
      end
    end
    if (cmd.pass_end) begin
      if (less <= rank) begin
        prefix <= cand;
      end
      bit_idx <= bit_idx - 1'b1;
    end
    if (cmd.div_start) begin
      sel <= cmd.div_sel;
    end
    if (div_done) begin
      case (sel)
        swls_pkg::DIV_MEAN: mean <= quot[SW_-1:0];
        default:            rate <= quot[swls_pkg::RATE_W-1:0];
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      total_count   <= total;
      mean_us       <= mean;
      min_us        <= mn;
      max_us        <= mx;
      pct99_us      <= pct_ok ? prefix : held_pct;
      pct99_valid   <= pct_ok;
      rate_millifps <= (mean == '0) ? '1 : rate;
    end
  end

  assign status.div_done  = div_done;
  assign status.scan_done = !scan_active && !rd_valid && !cmd.scan_start;
  assign status.last_bit  = (bit_idx == '0);
  assign status.mean_zero = (mean == '0);

endmodule

### hw/rtl/swls_ctrl.sv
// ----------------------------------------------------------------------------
// swls_ctrl
// Sequencer for one sample: store, bit search passes, mean and rate divides.
// ----------------------------------------------------------------------------
module swls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output swls_pkg::cmd_t    cmd,
  input  swls_pkg::status_t status
);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SCAN, S_STEP,
    S_MDIV, S_MWAIT, S_FDIV, S_FWAIT, S_PUT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd            = '0;
    cmd.div_sel    = swls_pkg::DIV_MEAN;
    case (state)
      S_IDLE:  cmd.write = in_valid;
      S_START: cmd.scan_start = 1'b1;
      S_STEP:  cmd.pass_end = 1'b1;
      S_MDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = swls_pkg::DIV_MEAN;
      end
      S_FDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = swls_pkg::DIV_RATE;
      end
      S_PUT:   cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == S_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE:  if (in_valid) state <= S_START;
        S_START: state <= S_SCAN;
        S_SCAN:  if (status.scan_done) state <= S_STEP;
        S_STEP:  state <= status.last_bit ? S_MDIV : S_START;
        S_MDIV:  state <= S_MWAIT;
        S_MWAIT: if (status.div_done) state <= S_FDIV;
        S_FDIV:  state <= status.mean_zero ? S_PUT : S_FWAIT;
        S_FWAIT: if (status.div_done) state <= S_PUT;
        S_PUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sliding_window_latency_stats.sv
// ----------------------------------------------------------------------------
// sliding_window_latency_stats
// Mean, min, max, 99th percentile and rate over the last WINDOW samples.
// ----------------------------------------------------------------------------
// One sample is taken at a time and yields one result beat. The divider is
// 32 bits wide, or 24 plus the fill count width if wider. The percentile is
// found by a 24-pass bitwise search that reads the window memory once per
// cycle, its rank comes from a constant multiply, and the mean and the rate
// come from one shared divider producing a quotient bit per cycle. A
// finished result waits in the output registers while the next sample is
// taken.
module sliding_window_latency_stats #(
  parameter int unsigned WINDOW = swls_pkg::WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [swls_pkg::SAMPLE_W-1:0] latency_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [swls_pkg::COUNT_W-1:0]  total_count,
  output logic [swls_pkg::SAMPLE_W-1:0] mean_us,
  output logic [swls_pkg::SAMPLE_W-1:0] min_us,
  output logic [swls_pkg::SAMPLE_W-1:0] max_us,
  output logic [swls_pkg::SAMPLE_W-1:0] pct99_us,
  output logic                          pct99_valid,
  output logic [swls_pkg::RATE_W-1:0]   rate_millifps
);

  swls_pkg::cmd_t    cmd;
  swls_pkg::status_t status;

  swls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  swls_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .latency_us    (latency_us),
    .total_count   (total_count),
    .mean_us       (mean_us),
    .min_us        (min_us),
    .max_us        (max_us),
    .pct99_us      (pct99_us),
    .pct99_valid   (pct99_valid),
    .rate_millifps (rate_millifps)
  );

endmodule
